// ----- rtl/ohlc_pkg.sv -----
// shared types and constants for the ohlc bar aggregator
// no dependencies
package ohlc_pkg;

  localparam int SLOT_W  = 8;
  localparam int TIME_W  = 63;
  localparam int PRICE_W = 64;
  localparam int VOL_W   = 63;
  localparam int IV_W    = 50;
  localparam int TICK_W  = 32;
  localparam int WIDE_W  = 64;

  localparam int NUM_SLOTS_DEF = 256;
  localparam int MAX_TBL       = 256;
  localparam logic [IV_W-1:0]   IV_RESET = IV_W'(64'd60000000000);
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic [TIME_W-1:0]         gen_ns;
    logic [TIME_W-1:0]         quote_ns;
    logic signed [PRICE_W-1:0] trade_px;
    logic [VOL_W-1:0]          cum_volume;
  } item_t;

  typedef struct packed {
    logic [TICK_W-1:0]         tick;
    logic [WIDE_W-1:0]         base;
    logic [WIDE_W-1:0]         wvol;
    logic signed [PRICE_W-1:0] open_p;
    logic signed [PRICE_W-1:0] high_p;
    logic signed [PRICE_W-1:0] low_p;
    logic signed [PRICE_W-1:0] close_p;
  } bar_t;

  typedef struct packed {
    logic [WIDE_W-1:0] win_start;
    logic [WIDE_W-1:0] win_end;
    bar_t              bar;
  } tbl_t;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic [TIME_W-1:0]         stamp_time;
    logic [TIME_W-1:0]         window_start;
    logic [TIME_W-1:0]         window_end;
    logic signed [PRICE_W-1:0] open_price;
    logic signed [PRICE_W-1:0] high_price;
    logic signed [PRICE_W-1:0] low_price;
    logic signed [PRICE_W-1:0] close_price;
    logic signed [PRICE_W-1:0] bar_volume;
    logic [TICK_W-1:0]         ticks;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_ALIGN, ST_EVAL, ST_EMIT, ST_GAP, ST_WRITE
  } seq_state_t;

endpackage

// ----- rtl/ohlc_bar_aggregator_unit.sv -----
// top level of the ohlc bar aggregator: ports, interval register, front and back
// depends on ohlc_pkg, ohlc_front, ohlc_back, ohlc_rem
//
// each quote updates the time bar of its table slot; a quote at or past the
// window end hands out the finished bar as one request on the result queue.
// a quote normally passes the back end as pop, table read, evaluate and write,
// the order set by the single-port read-modify-write of the slot table; a quote
// that closes a bar also passes an emit step and waits there while the result
// register is still full. a slot's first quote and a quote that skips whole
// windows also wait for the bit-serial remainder unit. a two-entry input queue
// lets quotes arrive while the back end works, and one result register holds
// a bar until popped. slots at or beyond NUM_SLOTS are accepted and dropped.
// an interval of zero acts as one. there is no clearing pass after reset.
module ohlc_bar_aggregator_unit #(
  parameter int NUM_SLOTS = ohlc_pkg::NUM_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [ohlc_pkg::SLOT_W-1:0]        in_slot,
  input  logic [ohlc_pkg::TIME_W-1:0]        in_gen_ns,
  input  logic [ohlc_pkg::TIME_W-1:0]        in_quote_ns,
  input  logic signed [ohlc_pkg::PRICE_W-1:0] in_trade_px,
  input  logic [ohlc_pkg::VOL_W-1:0]         in_cum_volume,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [ohlc_pkg::SLOT_W-1:0]        out_slot,
  output logic [ohlc_pkg::TIME_W-1:0]        out_stamp_time,
  output logic [ohlc_pkg::TIME_W-1:0]        out_window_start,
  output logic [ohlc_pkg::TIME_W-1:0]        out_window_end,
  output logic signed [ohlc_pkg::PRICE_W-1:0] out_open_price,
  output logic signed [ohlc_pkg::PRICE_W-1:0] out_high_price,
  output logic signed [ohlc_pkg::PRICE_W-1:0] out_low_price,
  output logic signed [ohlc_pkg::PRICE_W-1:0] out_close_price,
  output logic signed [ohlc_pkg::PRICE_W-1:0] out_bar_volume,
  output logic [ohlc_pkg::TICK_W-1:0]        out_ticks,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ohlc_pkg::IV_W-1:0]          cfg_interval_ns
);
  import ohlc_pkg::*;

  logic [IV_W-1:0] iv_r, iv_nxt, iv_eff;
  item_t           in_item, q_item;
  logic            q_valid, q_pop, res_valid;
  result_t         res;

  // configuration is always taken
  assign cfg_ready = 1'b1;
  assign iv_nxt    = (cfg_valid && cfg_ready) ? cfg_interval_ns : iv_r;
  // zero interval behaves as one
  assign iv_eff    = (iv_r == '0) ? IV_W'(1) : iv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= IV_RESET;
    else        iv_r <= iv_nxt;
  end

  assign in_item = '{slot: in_slot, gen_ns: in_gen_ns, quote_ns: in_quote_ns,
                     trade_px: in_trade_px, cum_volume: in_cum_volume};

  ohlc_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  ohlc_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .iv        (iv_eff),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_pop   (out_pop),
    .res       (res)
  );

  // result queue view of the output register
  assign out_empty        = !res_valid;
  assign out_slot         = res.slot;
  assign out_stamp_time   = res.stamp_time;
  assign out_window_start = res.window_start;
  assign out_window_end   = res.window_end;
  assign out_open_price   = res.open_price;
  assign out_high_price   = res.high_price;
  assign out_low_price    = res.low_price;
  assign out_close_price  = res.close_price;
  assign out_bar_volume   = res.bar_volume;
  assign out_ticks        = res.ticks;

endmodule

// ----- rtl/ohlc_rem.sv -----
// iterative restoring remainder unit, one quotient bit per cycle
// depends on ohlc_pkg
module ohlc_rem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ohlc_pkg::TIME_W-1:0]   dividend,
  input  logic [ohlc_pkg::IV_W-1:0]     divisor,
  output logic                          done,
  output logic [ohlc_pkg::IV_W-1:0]     rem
);
  import ohlc_pkg::*;

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] num_r, num_nxt;
  logic [IV_W:0]     rem_r, rem_nxt;
  logic [IV_W-1:0]   dvs_r, dvs_nxt;
  logic [IV_W:0]     sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    sh       = {rem_r[IV_W-1:0], num_r[TIME_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(TIME_W);
      num_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = (sh >= {1'b0, dvs_r}) ? sh - {1'b0, dvs_r} : sh;
      num_nxt = {num_r[TIME_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[IV_W-1:0];

endmodule

// ----- rtl/ohlc_front.sv -----
// input side: accepts quotes, drops slots beyond the table, two-entry queue
// depends on ohlc_pkg
module ohlc_front #(
  parameter int NUM_SLOTS = ohlc_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ohlc_pkg::item_t     in_item,
  output logic                q_valid,
  input  logic                q_pop,
  output ohlc_pkg::item_t     q_item
);
  import ohlc_pkg::*;

  item_t       buf_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        enq, deq;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = buf_r[rp_r];
  // out of range slots are taken and discarded here
  assign enq     = push && !full && (32'(in_item.slot) < 32'(NUM_SLOTS));
  assign deq     = q_pop && q_valid;

  always_comb begin
    wp_nxt  = enq ? ~wp_r : wp_r;
    rp_nxt  = deq ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (enq) buf_r[wp_r] <= in_item;
  end

endmodule

// ----- rtl/ohlc_back.sv -----
// back end: per-slot bar table, update sequencer and result register
// depends on ohlc_pkg and ohlc_rem
module ohlc_back #(
  parameter int NUM_SLOTS = ohlc_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ohlc_pkg::IV_W-1:0]     iv,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  ohlc_pkg::item_t               q_item,
  output logic                          res_valid,
  input  logic                          res_pop,
  output ohlc_pkg::result_t             res
);
  import ohlc_pkg::*;

  localparam int TBL_DEPTH = (NUM_SLOTS < MAX_TBL) ? NUM_SLOTS : MAX_TBL;
  localparam int AW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  tbl_t            mem [TBL_DEPTH];
  logic            used_r [TBL_DEPTH];
  tbl_t            rd_q;
  logic            rd_used_r;

  seq_state_t      st_r, st_nxt;
  item_t           item_r;
  logic [WIDE_W-1:0] start_r, end_r;
  bar_t            bar_r, upd_bar, fresh;
  result_t         res_r;
  logic            res_valid_r;

  logic            div_go, div_done;
  logic [IV_W-1:0] div_rem;
  logic [TIME_W-1:0] div_in;
  logic [AW-1:0]   q_idx, w_idx;

  logic [WIDE_W-1:0] dt, gen, ivw, vol, gap, st_gap, st_align;
  logic            in_win, emit_hit, need_gap, can_emit;

  assign dt   = {1'b0, item_r.quote_ns};
  assign gen  = {1'b0, item_r.gen_ns};
  assign ivw  = {{(WIDE_W-IV_W){1'b0}}, iv};
  assign vol  = {1'b0, item_r.cum_volume};
  assign q_idx = q_item.slot[AW-1:0];
  assign w_idx = item_r.slot[AW-1:0];

  assign in_win   = (dt >= start_r) && (dt <= end_r);
  assign emit_hit = (dt >= end_r);
  assign need_gap = ({1'b0, end_r} + {1'b0, ivw}) < {1'b0, dt};
  assign gap      = dt - end_r - ivw;
  assign can_emit = !res_valid_r || res_pop;
  assign st_gap   = (div_rem != '0) ? dt - {{(WIDE_W-IV_W){1'b0}}, div_rem} : dt - ivw;
  assign st_align = gen - {{(WIDE_W-IV_W){1'b0}}, div_rem};
  assign div_in   = (st_r == ST_READ) ? item_r.gen_ns : gap[TIME_W-1:0];

  ohlc_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_in),
    .divisor  (iv),
    .done     (div_done),
    .rem      (div_rem)
  );

  // bar update for a tick inside the window
  always_comb begin
    upd_bar = bar_r;
    if (bar_r.tick == '0) begin
      upd_bar.open_p = item_r.trade_px;
      upd_bar.high_p = item_r.trade_px;
      upd_bar.low_p  = item_r.trade_px;
      upd_bar.base   = vol;
    end
    if (bar_r.tick != TICK_MAX) upd_bar.tick = bar_r.tick + 1'b1;
    upd_bar.wvol = vol - upd_bar.base;
    if (item_r.trade_px > upd_bar.high_p) upd_bar.high_p = item_r.trade_px;
    if (item_r.trade_px < upd_bar.low_p)  upd_bar.low_p  = item_r.trade_px;
    upd_bar.close_p = item_r.trade_px;

    fresh         = '0;
    fresh.tick    = TICK_W'(1);
    fresh.base    = vol;
    fresh.open_p  = item_r.trade_px;
    fresh.high_p  = item_r.trade_px;
    fresh.low_p   = item_r.trade_px;
    fresh.close_p = item_r.trade_px;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (q_valid) st_nxt = ST_READ;
      ST_READ:  st_nxt = rd_used_r ? ST_EVAL : ST_ALIGN;
      ST_ALIGN: if (div_done) st_nxt = ST_EVAL;
      ST_EVAL:  st_nxt = emit_hit ? ST_EMIT : ST_WRITE;
      ST_EMIT:  if (can_emit) st_nxt = need_gap ? ST_GAP : ST_WRITE;
      ST_GAP:   if (div_done) st_nxt = ST_WRITE;
      ST_WRITE: st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = 1'b0;
    div_go = 1'b0;
    case (st_r)
      ST_IDLE: q_pop  = q_valid;
      ST_READ: div_go = !rd_used_r;
      ST_EMIT: div_go = can_emit && need_gap;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      res_valid_r <= 1'b0;
      for (int i = 0; i < TBL_DEPTH; i++) used_r[i] <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_EMIT && can_emit) res_valid_r <= 1'b1;
      else if (res_pop)                res_valid_r <= 1'b0;
      if (st_r == ST_WRITE) used_r[w_idx] <= 1'b1;
    end

    if (q_pop) begin
      item_r    <= q_item;
      rd_q      <= mem[q_idx];
      rd_used_r <= used_r[q_idx];
    end
    if (st_r == ST_WRITE) mem[w_idx] <= '{win_start: start_r, win_end: end_r, bar: bar_r};

    case (st_r)
      ST_READ: begin
        start_r <= rd_q.win_start;
        end_r   <= rd_q.win_end;
        bar_r   <= rd_used_r ? rd_q.bar : '0;
      end
      ST_ALIGN: if (div_done) begin
        start_r <= st_align;
        end_r   <= st_align + ivw;
      end
      ST_EVAL: if (in_win) bar_r <= upd_bar;
      ST_EMIT: if (can_emit) begin
        res_r <= '{slot: item_r.slot, stamp_time: item_r.gen_ns,
                   window_start: start_r[TIME_W-1:0], window_end: end_r[TIME_W-1:0],
                   open_price: bar_r.open_p, high_price: bar_r.high_p,
                   low_price: bar_r.low_p, close_price: bar_r.close_p,
                   bar_volume: bar_r.wvol, ticks: bar_r.tick};
        if (!need_gap) begin
          start_r <= end_r;
          end_r   <= end_r + ivw;
          bar_r   <= fresh;
        end
      end
      ST_GAP: if (div_done) begin
        start_r <= st_gap;
        end_r   <= st_gap + ivw;
        bar_r   <= fresh;
      end
      default: ;
    endcase
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
